>>> src/triple_incremental_pi_regulator_defines.svh
// assertion macros for the triple pi regulator checker
// used by tipr_checker.sv, expects clk and rst in scope
`ifndef TRIPLE_INCREMENTAL_PI_REGULATOR_DEFINES_SVH
`define TRIPLE_INCREMENTAL_PI_REGULATOR_DEFINES_SVH

// clocked assertion, switched off while in reset
`define TIPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form of the above
`define TIPR_ASSERT_IMP(label, cond, prop, msg) \
  `TIPR_ASSERT(label, (cond) |-> (prop), msg)

`endif

>>> src/tipr_pkg.sv
// shared types and constants of the triple pi regulator
// no dependencies; used by tipr_step, the top level and the checker
`timescale 1ns / 1ps

package tipr_pkg;

  typedef enum logic [1:0] {
    LOOP_SPEED = 2'd0,
    LOOP_Q     = 2'd1,
    LOOP_D     = 2'd2,
    LOOP_NONE  = 2'd3
  } loop_t;

  typedef enum logic [2:0] {
    CFG_SPEED_REF   = 3'd0,
    CFG_SPEED_KP    = 3'd1,
    CFG_SPEED_KI_TS = 3'd2,
    CFG_Q_KP        = 3'd3,
    CFG_Q_KI_TS     = 3'd4,
    CFG_D_KP        = 3'd5,
    CFG_D_KI_TS     = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  localparam int NUM_LOOPS = 3;

  // +-5.0 and +-12.0 in q16.16
  localparam logic signed [20:0] SPEED_CLAMP   = 21'sd327680;
  localparam logic signed [20:0] CURRENT_CLAMP = 21'sd786432;

  typedef struct packed {
    logic signed [31:0] target;
    logic        [31:0] kp;
    logic        [31:0] ki;
    logic signed [31:0] prev_err;
    logic signed [20:0] prev_out;
    logic signed [20:0] limit;
  } step_req_t;

  typedef struct packed {
    logic signed [31:0] err;
    logic signed [20:0] out;
  } step_res_t;

endpackage

>>> src/tipr_step.sv
// one velocity-form pi step: saturated error, two q16.16 products, clamp
// depends on tipr_pkg
`timescale 1ns / 1ps

module tipr_step (
  input  tipr_pkg::step_req_t req,
  input  logic signed [31:0]  measured,
  output tipr_pkg::step_res_t res
);

  logic signed [32:0] err_full;
  logic signed [31:0] err;
  logic signed [32:0] diff;
  logic signed [65:0] p_prod;
  logic signed [65:0] i_prod;
  logic signed [49:0] p_term;
  logic signed [49:0] i_term;
  logic signed [51:0] acc;
  logic signed [51:0] lim_hi;
  logic signed [51:0] lim_lo;
  logic signed [20:0] neg_limit;

  always_comb begin
    err_full = {req.target[31], req.target} - {measured[31], measured};
    if (err_full[32] != err_full[31]) begin
      err = err_full[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err = err_full[31:0];
    end

    diff   = {err[31], err} - {req.prev_err[31], req.prev_err};
    p_prod = $signed({1'b0, req.kp}) * diff;
    i_prod = $signed({1'b0, req.ki}) * $signed({err[31], err});
    // arithmetic drop of 16 bits gives the floor
    p_term = p_prod[65:16];
    i_term = i_prod[65:16];

    acc = {{31{req.prev_out[20]}}, req.prev_out}
        + {{2{p_term[49]}}, p_term}
        + {{2{i_term[49]}}, i_term};

    neg_limit = -req.limit;
    lim_hi    = {{31{req.limit[20]}}, req.limit};
    lim_lo    = {{31{neg_limit[20]}}, neg_limit};

    res.err = err;
    if (acc >= lim_hi) begin
      res.out = req.limit;
    end else if (acc < lim_lo) begin
      res.out = neg_limit;
    end else begin
      res.out = acc[20:0];
    end
  end

endmodule

>>> src/triple_incremental_pi_regulator.sv
// top level of the triple pi regulator: config registers, loop state, handshake
// depends on tipr_pkg and tipr_step
`timescale 1ns / 1ps

// Three incremental pi loops (speed, q current, d current) sharing one datapath.
// Input stream: s_tuser picks the loop, s_tdata carries the measurement and the
// q reference. Each request gives exactly one result on the m_ stream: the loop
// code in m_tuser and the new clamped loop output in m_tdata.
// m_tvalid rises once an accepted request has passed from the input register
// through the step logic (two 33x33 multiplies, sum, clamp) into the output
// register. Throughput is one request per cycle while results are taken, also
// back to back on the same loop, since the loop state is written at the same
// edge as the output register.
// When the receiver stalls, the result is held, the input register still fills,
// and s_tready drops once both registers hold work.
// Loop code 3 gives a result of code 3 with value zero and leaves state alone.
// Configuration (cfg_we, cfg_index, cfg_data) takes effect the next cycle. The user must
// write it only while no request is in flight; the block does not check. Indexes beyond 6 are ignored.
// Synchronous reset clears the gains, the speed reference, both valid flags and
// all loop outputs and previous errors.
module triple_incremental_pi_regulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured, [63:32] q_target
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] drive_value, [23:21] zero
  output logic [1:0]  m_tuser,   // [1:0] loop_id
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] speed_reference;
  logic [31:0] speed_kp;
  logic [31:0] speed_ki_ts;
  logic [31:0] q_kp;
  logic [31:0] q_ki_ts;
  logic [31:0] d_kp;
  logic [31:0] d_ki_ts;

  logic signed [20:0] loop_output [tipr_pkg::NUM_LOOPS];
  logic signed [31:0] previous_error [tipr_pkg::NUM_LOOPS];

  logic               in_valid;
  tipr_pkg::loop_t    in_op;
  logic signed [31:0] in_measured;
  logic signed [31:0] in_q_target;

  logic signed [20:0] drive_value;

  logic                advance;
  tipr_pkg::step_req_t req;
  tipr_pkg::step_res_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {3'b000, drive_value};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reference <= '0;
      speed_kp        <= '0;
      speed_ki_ts     <= '0;
      q_kp            <= '0;
      q_ki_ts         <= '0;
      d_kp            <= '0;
      d_ki_ts         <= '0;
    end else if (cfg_we) begin
      case (tipr_pkg::cfg_idx_t'(cfg_index))
        tipr_pkg::CFG_SPEED_REF:   speed_reference <= cfg_data;
        tipr_pkg::CFG_SPEED_KP:    speed_kp        <= cfg_data;
        tipr_pkg::CFG_SPEED_KI_TS: speed_ki_ts     <= cfg_data;
        tipr_pkg::CFG_Q_KP:        q_kp            <= cfg_data;
        tipr_pkg::CFG_Q_KI_TS:     q_ki_ts         <= cfg_data;
        tipr_pkg::CFG_D_KP:        d_kp            <= cfg_data;
        tipr_pkg::CFG_D_KI_TS:     d_ki_ts         <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op       <= tipr_pkg::loop_t'(s_tuser);
      in_measured <= s_tdata[31:0];
      in_q_target <= s_tdata[63:32];
    end
  end

  // pick reference, gains and state of the addressed loop
  always_comb begin
    req.kp       = d_kp;
    req.ki       = d_ki_ts;
    req.target   = '0;
    req.prev_err = previous_error[tipr_pkg::LOOP_D];
    req.prev_out = loop_output[tipr_pkg::LOOP_D];
    req.limit    = tipr_pkg::CURRENT_CLAMP;
    case (in_op)
      tipr_pkg::LOOP_SPEED: begin
        req.target   = speed_reference;
        req.kp       = speed_kp;
        req.ki       = speed_ki_ts;
        req.prev_err = previous_error[tipr_pkg::LOOP_SPEED];
        req.prev_out = loop_output[tipr_pkg::LOOP_SPEED];
        req.limit    = tipr_pkg::SPEED_CLAMP;
      end
      tipr_pkg::LOOP_Q: begin
        req.target   = in_q_target;
        req.kp       = q_kp;
        req.ki       = q_ki_ts;
        req.prev_err = previous_error[tipr_pkg::LOOP_Q];
        req.prev_out = loop_output[tipr_pkg::LOOP_Q];
      end
      default: ;
    endcase
  end

  tipr_step u_step (
    .req      (req),
    .measured (in_measured),
    .res      (res)
  );

  // loop state, updated as the result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tipr_pkg::NUM_LOOPS; i++) begin
        loop_output[i]    <= '0;
        previous_error[i] <= '0;
      end
    end else if (advance) begin
      case (in_op)
        tipr_pkg::LOOP_SPEED: begin
          loop_output[tipr_pkg::LOOP_SPEED]    <= res.out;
          previous_error[tipr_pkg::LOOP_SPEED] <= res.err;
        end
        tipr_pkg::LOOP_Q: begin
          loop_output[tipr_pkg::LOOP_Q]    <= res.out;
          previous_error[tipr_pkg::LOOP_Q] <= res.err;
        end
        tipr_pkg::LOOP_D: begin
          loop_output[tipr_pkg::LOOP_D]    <= res.out;
          previous_error[tipr_pkg::LOOP_D] <= res.err;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser     <= in_op;
      drive_value <= (in_op == tipr_pkg::LOOP_NONE) ? 21'sd0 : res.out;
    end
  end

endmodule

>>> src/tipr_checker.sv
// port-level checks on the triple pi regulator result stream, bound to the top
// depends on tipr_pkg and triple_incremental_pi_regulator_defines.svh
`timescale 1ns / 1ps
`include "triple_incremental_pi_regulator_defines.svh"

module tipr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic signed [20:0] drive;
  logic [25:0]        result;
  logic               stalled;
  logic               is_none;
  logic               is_speed;
  logic               is_current;
  logic               speed_ok;
  logic               current_ok;

  assign drive      = m_tdata[20:0];
  assign result     = {m_tuser, m_tdata};
  assign stalled    = m_tvalid && !m_tready;
  assign is_none    = m_tvalid && (m_tuser == tipr_pkg::LOOP_NONE);
  assign is_speed   = m_tvalid && (m_tuser == tipr_pkg::LOOP_SPEED);
  assign is_current = m_tvalid && ((m_tuser == tipr_pkg::LOOP_Q) ||
                                   (m_tuser == tipr_pkg::LOOP_D));
  assign speed_ok   = (drive <= tipr_pkg::SPEED_CLAMP) && (drive >= -tipr_pkg::SPEED_CLAMP);
  // padding clear as well
  assign current_ok = (drive <= tipr_pkg::CURRENT_CLAMP) &&
                      (drive >= -tipr_pkg::CURRENT_CLAMP) && (m_tdata[23:21] == 3'd0);

  // a stalled result stays put
  `TIPR_ASSERT_IMP(a_hold, stalled, ##1 (m_tvalid && $stable(result)), "stalled result changed")

  // the unused loop code answers with zero
  `TIPR_ASSERT_IMP(a_none_zero, is_none, m_tdata == 24'd0, "unused loop code gave a nonzero value")

  // speed output within +-5.0
  `TIPR_ASSERT_IMP(a_speed_clamp, is_speed, speed_ok, "speed output outside its clamp")

  // current outputs within +-12.0
  `TIPR_ASSERT_IMP(a_current_clamp, is_current, current_ok, "current output outside its clamp")

endmodule

bind triple_incremental_pi_regulator tipr_checker u_tipr_checker (.*);
